// ===== design/tcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and codes for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // request kinds
   localparam logic [1:0] KIND_PUT       = 2'd0;
   localparam logic [1:0] KIND_BACKSPACE = 2'd1;
   localparam logic [1:0] KIND_CLEAR     = 2'd2;
   localparam logic [1:0] KIND_READ      = 2'd3;

   // register indexes
   localparam logic CSR_DEFAULT_ATTR = 1'b0;
   localparam logic CSR_ERROR_ATTR   = 1'b1;

   localparam logic [7:0] DEFAULT_ATTR_RST = 8'h0f;
   localparam logic [7:0] ERROR_ATTR_RST   = 8'hf4;

   // character codes
   localparam logic [7:0] CH_NEWLINE = 8'd10;
   localparam logic [7:0] CH_RETURN  = 8'd13;
   localparam logic [7:0] CH_SPACE   = 8'd32;
   localparam logic [7:0] CH_ERROR   = 8'd69;
   localparam logic [7:0] CH_NUL     = 8'd0;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_SCROLL_COPY,
      ST_SCROLL_FILL,
      ST_DONE
   } tcw_state_type;

   // decoded request: one cell access plus the cursor update
   typedef struct packed {
      logic        wr_en;
      logic        rd_en;
      logic [15:0] wr_data;
      logic [6:0]  acc_col;
      logic [4:0]  acc_row;
      logic        cur_en;
      logic [6:0]  cur_col;
      logic [4:0]  cur_row;
      logic        scroll;
      logic        clear;
      logic        oor;
   } tcw_op_type;

endpackage

// ===== design/tcw_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_decode
// Decodes one request against the cursor: which cell is touched, with what
// data, and where the cursor goes.
// ----------------------------------------------------------------------------
module tcw_decode import tcw_pkg::*; #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic [1:0]  kind,
   input  logic [7:0]  ch,
   input  logic [7:0]  attr,
   input  logic [6:0]  col,
   input  logic [4:0]  row,
   input  logic        at_cursor,
   input  logic [6:0]  cur_col,
   input  logic [4:0]  cur_row,
   input  logic [7:0]  default_attr,
   input  logic [7:0]  error_attr,
   output tcw_op_type  op
);

   localparam logic [7:0] COL_LIM  = 8'(COLUMNS);
   localparam logic [5:0] ROW_LIM  = 6'(ROWS);
   localparam logic [6:0] COL_LAST = 7'(COLUMNS - 1);
   localparam logic [4:0] ROW_LAST = 5'(ROWS - 1);
   // backspace from column 0 lands in the last column, which must be >= 2
   localparam logic       BS_WRAP  = (COLUMNS >= 3);

   logic [6:0] eff_col;
   logic [4:0] eff_row;
   logic       oor;
   logic [7:0] put_attr;
   logic [7:0] col_inc;
   logic [5:0] row_inc;
   logic [5:0] nrow;

   always_comb begin
      eff_col  = at_cursor ? cur_col : col;
      eff_row  = at_cursor ? cur_row : row;
      oor      = ({1'b0, eff_col} >= COL_LIM) || ({1'b0, eff_row} >= ROW_LIM);
      put_attr = (attr != 8'd0) ? attr : default_attr;
      col_inc  = {1'b0, eff_col} + 8'd1;
      row_inc  = {1'b0, eff_row} + 6'd1;
      nrow     = {1'b0, eff_row};

      op         = '0;
      op.acc_col = eff_col;
      op.acc_row = eff_row;
      op.cur_col = cur_col;
      op.cur_row = cur_row;

      case (kind)
         KIND_PUT: begin
            if (oor) begin
               op.oor     = 1'b1;
               op.wr_en   = 1'b1;
               op.acc_col = COL_LAST;
               op.acc_row = ROW_LAST;
               op.wr_data = {error_attr, CH_ERROR};
            end else begin
               op.cur_en = 1'b1;
               if (ch == CH_NEWLINE) begin
                  op.cur_col = eff_col;
                  nrow       = row_inc;
               end else if (ch == CH_RETURN) begin
                  op.cur_col = 7'd0;
               end else begin
                  op.wr_en   = 1'b1;
                  op.wr_data = {put_attr, ch};
                  if (col_inc == COL_LIM) begin
                     op.cur_col = 7'd0;
                     nrow       = row_inc;
                  end else begin
                     op.cur_col = col_inc[6:0];
                  end
               end
               if (nrow == ROW_LIM) begin
                  op.scroll  = 1'b1;
                  op.cur_row = ROW_LAST;
               end else begin
                  op.cur_row = nrow[4:0];
               end
            end
         end
         KIND_BACKSPACE: begin
            op.wr_data = {default_attr, CH_NUL};
            if (cur_col == 7'd0) begin
               if (cur_row != 5'd0 && BS_WRAP) begin
                  op.wr_en   = 1'b1;
                  op.cur_en  = 1'b1;
                  op.cur_col = COL_LAST;
                  op.cur_row = cur_row - 5'd1;
               end
            end else if (cur_col >= 7'd3) begin
               op.wr_en   = 1'b1;
               op.cur_en  = 1'b1;
               op.cur_col = cur_col - 7'd1;
               op.cur_row = cur_row;
            end
            op.acc_col = op.cur_col;
            op.acc_row = op.cur_row;
         end
         KIND_CLEAR: begin
            op.clear   = 1'b1;
            op.cur_en  = 1'b1;
            op.cur_col = 7'd0;
            op.cur_row = 5'd0;
         end
         KIND_READ: begin
            op.oor   = oor;
            op.rd_en = !oor;
         end
         default: begin
            op = '0;
         end
      endcase
   end

endmodule

// ===== design/text_console_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console: character/attribute screen buffer in one synchronous
// RAM, a cursor, put / backspace / clear / read requests, scroll on overflow.
// ----------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  req      in         req_valid/stall     kind ch attr col row at_cursor
//  rsp      out        rsp_valid/stall     cursor_col/row out_of_range scrolled
//                                          cell_char cell_attr
//  csr      in         csr_we              csr_index csr_wdata
//
//  Put, backspace and read pass through accept (RAM access) and result load.
//  Clear walks the RAM, writing every cell. A scroll copies every row up
//  through the single RAM port pair and zeroes the bottom row.
//  After reset a clearing pass zeroes the RAM; no request is taken until
//  it ends. A request is taken while an earlier result still waits under
//  rsp_stall; its own result then waits in turn.
// ----------------------------------------------------------------------------
module text_console_writer import tcw_pkg::*; #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_ch,
   input  logic [7:0]  req_attr,
   input  logic [6:0]  req_col,
   input  logic [4:0]  req_row,
   input  logic        req_at_cursor,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_cursor_col,
   output logic [4:0]  rsp_cursor_row,
   output logic        rsp_out_of_range,
   output logic        rsp_scrolled,
   output logic [7:0]  rsp_cell_char,
   output logic [7:0]  rsp_cell_attr,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] ADDR_COLS = ADDR_W'(COLUMNS);
   localparam logic [ADDR_W-1:0] ADDR_FILL = ADDR_W'(CELLS - COLUMNS);
   localparam logic [ADDR_W-1:0] ADDR_ONE  = ADDR_W'(1);

   tcw_state_type     state_ff, state_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [6:0]        cur_col_ff, cur_col_in;
   logic [4:0]        cur_row_ff, cur_row_in;
   logic              oor_ff, oor_in;
   logic              scr_ff, scr_in;
   logic              rdsel_ff, rdsel_in;
   logic              copy_pend_ff, copy_pend_in;
   logic [ADDR_W-1:0] copy_wa_ff, copy_wa_in;
   logic [7:0]        default_attr_ff, default_attr_in;
   logic [7:0]        error_attr_ff, error_attr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_load;

   logic [6:0]        rsp_col_ff;
   logic [4:0]        rsp_row_ff;
   logic              rsp_oor_ff;
   logic              rsp_scr_ff;
   logic [7:0]        rsp_char_ff;
   logic [7:0]        rsp_attr_ff;

   logic [15:0]       screen_mem [CELLS];
   logic [15:0]       mem_rd_ff;
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_wa, mem_ra;
   logic [15:0]       mem_wd;
   logic [ADDR_W-1:0] acc_addr;
   logic              req_take;

   tcw_op_type        op;

   tcw_decode #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) u_decode (
      .kind        (req_kind),
      .ch          (req_ch),
      .attr        (req_attr),
      .col         (req_col),
      .row         (req_row),
      .at_cursor   (req_at_cursor),
      .cur_col     (cur_col_ff),
      .cur_row     (cur_row_ff),
      .default_attr(default_attr_ff),
      .error_attr  (error_attr_ff),
      .op          (op)
   );

   assign acc_addr  = ADDR_W'(op.acc_row) * ADDR_COLS + ADDR_W'(op.acc_col);
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      oor_in       = oor_ff;
      scr_in       = scr_ff;
      rdsel_in     = rdsel_ff;
      copy_pend_in = (state_ff == ST_SCROLL_COPY);
      copy_wa_in   = idx_ff - ADDR_COLS;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_load     = 1'b0;
      mem_we       = 1'b0;
      mem_wa       = acc_addr;
      mem_wd       = op.wr_data;
      mem_re       = 1'b0;
      mem_ra       = acc_addr;

      // a copied cell lands in the cycle after its read; it owns the write port
      if (copy_pend_ff) begin
         mem_we = 1'b1;
         mem_wa = copy_wa_ff;
         mem_wd = mem_rd_ff;
      end

      case (state_ff)
         ST_INIT: begin
            mem_we = 1'b1;
            mem_wa = idx_ff;
            mem_wd = 16'd0;
            idx_in = idx_ff + ADDR_ONE;
            if (idx_ff == ADDR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               mem_we   = op.wr_en;
               mem_re   = op.rd_en;
               oor_in   = op.oor;
               scr_in   = op.scroll;
               rdsel_in = op.rd_en;
               if (op.cur_en) begin
                  cur_col_in = op.cur_col;
                  cur_row_in = op.cur_row;
               end
               if (op.clear) begin
                  idx_in   = '0;
                  state_in = ST_CLEAR;
               end else if (op.scroll) begin
                  idx_in   = ADDR_COLS;
                  state_in = ST_SCROLL_COPY;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = idx_ff;
            mem_wd = {default_attr_ff, CH_SPACE};
            idx_in = idx_ff + ADDR_ONE;
            if (idx_ff == ADDR_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_SCROLL_COPY: begin
            mem_re = 1'b1;
            mem_ra = idx_ff;
            idx_in = idx_ff + ADDR_ONE;
            if (idx_ff == ADDR_LAST) begin
               idx_in   = ADDR_FILL;
               state_in = ST_SCROLL_FILL;
            end
         end
         ST_SCROLL_FILL: begin
            if (!copy_pend_ff) begin
               mem_we = 1'b1;
               mem_wa = idx_ff;
               mem_wd = 16'd0;
               idx_in = idx_ff + ADDR_ONE;
               if (idx_ff == ADDR_LAST) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      default_attr_in = default_attr_ff;
      error_attr_in   = error_attr_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DEFAULT_ATTR: default_attr_in = csr_wdata;
            CSR_ERROR_ATTR:   error_attr_in   = csr_wdata;
            default:          default_attr_in = default_attr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_INIT;
         idx_ff          <= '0;
         cur_col_ff      <= 7'd0;
         cur_row_ff      <= 5'd0;
         oor_ff          <= 1'b0;
         scr_ff          <= 1'b0;
         rdsel_ff        <= 1'b0;
         copy_pend_ff    <= 1'b0;
         default_attr_ff <= DEFAULT_ATTR_RST;
         error_attr_ff   <= ERROR_ATTR_RST;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         idx_ff          <= idx_in;
         cur_col_ff      <= cur_col_in;
         cur_row_ff      <= cur_row_in;
         oor_ff          <= oor_in;
         scr_ff          <= scr_in;
         rdsel_ff        <= rdsel_in;
         copy_pend_ff    <= copy_pend_in;
         default_attr_ff <= default_attr_in;
         error_attr_ff   <= error_attr_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      copy_wa_ff <= copy_wa_in;
      if (rsp_load) begin
         rsp_col_ff  <= cur_col_ff;
         rsp_row_ff  <= cur_row_ff;
         rsp_oor_ff  <= oor_ff;
         rsp_scr_ff  <= scr_ff;
         rsp_char_ff <= rdsel_ff ? mem_rd_ff[7:0]  : 8'd0;
         rsp_attr_ff <= rdsel_ff ? mem_rd_ff[15:8] : 8'd0;
      end
   end

   // screen buffer: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         mem_rd_ff <= screen_mem[mem_ra];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cursor_col   = rsp_col_ff;
   assign rsp_cursor_row   = rsp_row_ff;
   assign rsp_out_of_range = rsp_oor_ff;
   assign rsp_scrolled     = rsp_scr_ff;
   assign rsp_cell_char    = rsp_char_ff;
   assign rsp_cell_attr    = rsp_attr_ff;

endmodule

// ===== bench/text_console_writer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_test
// Drives put, backspace, clear and read requests into the console engine and
// checks each response against a cycle-free model of the screen buffer and
// cursor. Directed corner cases first, then random traffic in several idle
// and stall phases, with the attribute registers reprogrammed between phases.
// ----------------------------------------------------------------------------
module text_console_writer_test import tcw_pkg::*;;

   localparam int NUM_COLS         = 80;
   localparam int NUM_ROWS         = 25;
   localparam int NUM_CELLS        = NUM_COLS * NUM_ROWS;
   localparam int WATCHDOG_LIMIT   = 20000;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int PHASE_ITEMS      = 275;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] ch;
      logic [7:0] attr;
      logic [6:0] col;
      logic [4:0] row;
      logic       at_cursor;
   } console_req_type;

   typedef struct packed {
      logic [6:0] cursor_col;
      logic [4:0] cursor_row;
      logic       out_of_range;
      logic       scrolled;
      logic [7:0] cell_char;
      logic [7:0] cell_attr;
   } console_rsp_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_kind = KIND_PUT;
   logic [7:0] req_ch = 8'd0;
   logic [7:0] req_attr = 8'd0;
   logic [6:0] req_col = 7'd0;
   logic [4:0] req_row = 5'd0;
   logic       req_at_cursor = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [6:0] rsp_cursor_col;
   logic [4:0] rsp_cursor_row;
   logic       rsp_out_of_range;
   logic       rsp_scrolled;
   logic [7:0] rsp_cell_char;
   logic [7:0] rsp_cell_attr;
   logic       csr_we = 1'b0;
   logic       csr_index = CSR_DEFAULT_ATTR;
   logic [7:0] csr_wdata = 8'd0;

   text_console_writer #(
      .COLUMNS(NUM_COLS),
      .ROWS(NUM_ROWS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_ch(req_ch),
      .req_attr(req_attr),
      .req_col(req_col),
      .req_row(req_row),
      .req_at_cursor(req_at_cursor),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_cursor_col(rsp_cursor_col),
      .rsp_cursor_row(rsp_cursor_row),
      .rsp_out_of_range(rsp_out_of_range),
      .rsp_scrolled(rsp_scrolled),
      .rsp_cell_char(rsp_cell_char),
      .rsp_cell_attr(rsp_cell_attr),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // screen model
   logic [15:0]  screen_model [NUM_CELLS];
   int           cursor_pos;
   logic [7:0]   default_attr_cfg;
   logic [7:0]   error_attr_cfg;

   console_req_type pending_reqs [$];
   console_rsp_type expected_rsps [$];
   int           outstanding = 0;
   int           mismatch_count = 0;
   int           send_gap_pct = 0;
   int           stall_pct = 0;
   logic         long_hold_armed = 1'b0;
   int           hold_cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic console_rsp_type apply_console_request(console_req_type r);
      console_rsp_type res;
      int c;
      int rw;
      int pos;
      int prev;
      int i;
      res = '0;
      c = r.col;
      rw = r.row;
      if (r.at_cursor) begin
         c = cursor_pos % NUM_COLS;
         rw = cursor_pos / NUM_COLS;
      end
      case (r.kind)
         KIND_PUT: begin
            if (c >= NUM_COLS || rw >= NUM_ROWS) begin
               screen_model[NUM_CELLS-1] = {error_attr_cfg, CH_ERROR};
               res.out_of_range = 1'b1;
            end else begin
               pos = rw * NUM_COLS + c;
               if (r.ch == CH_NEWLINE) begin
                  pos = pos + NUM_COLS;
               end else if (r.ch == CH_RETURN) begin
                  pos = rw * NUM_COLS;
               end else begin
                  screen_model[pos] = {((r.attr != 8'd0) ? r.attr : default_attr_cfg), r.ch};
                  pos++;
               end
               if (pos >= NUM_CELLS) begin
                  for (i = 0; i < NUM_CELLS - NUM_COLS; i++)
                     screen_model[i] = screen_model[i + NUM_COLS];
                  for (i = NUM_CELLS - NUM_COLS; i < NUM_CELLS; i++)
                     screen_model[i] = 16'd0;
                  pos = pos - NUM_COLS;
                  res.scrolled = 1'b1;
               end
               cursor_pos = pos;
            end
         end
         KIND_BACKSPACE: begin
            // no-op at the top left cell or when the previous cell is in column 0 or 1
            if (cursor_pos != 0) begin
               prev = cursor_pos - 1;
               if (prev % NUM_COLS >= 2) begin
                  screen_model[prev] = {default_attr_cfg, CH_NUL};
                  cursor_pos = prev;
               end
            end
         end
         KIND_CLEAR: begin
            for (i = 0; i < NUM_CELLS; i++)
               screen_model[i] = {default_attr_cfg, CH_SPACE};
            cursor_pos = 0;
         end
         default: begin
            if (c >= NUM_COLS || rw >= NUM_ROWS) begin
               res.out_of_range = 1'b1;
            end else begin
               res.cell_char = screen_model[rw * NUM_COLS + c][7:0];
               res.cell_attr = screen_model[rw * NUM_COLS + c][15:8];
            end
         end
      endcase
      res.cursor_col = 7'(cursor_pos % NUM_COLS);
      res.cursor_row = 5'(cursor_pos / NUM_COLS);
      return res;
   endfunction

   function automatic console_req_type random_console_request();
      console_req_type r;
      int pick;
      r.kind = KIND_PUT;
      r.ch = 8'($urandom_range(0, 255));
      r.attr = 8'($urandom_range(0, 255));
      r.col = 7'($urandom_range(0, 127));
      r.row = 5'($urandom_range(0, 31));
      r.at_cursor = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
         r.kind = KIND_CLEAR;
      end else if (pick < 12) begin
         r.kind = KIND_BACKSPACE;
      end else if (pick < 27) begin
         r.kind = KIND_READ;
         r.at_cursor = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) != 0) begin
            r.col = 7'($urandom_range(0, NUM_COLS - 1));
            r.row = 5'($urandom_range(0, NUM_ROWS - 1));
         end
      end else begin
         r.at_cursor = ($urandom_range(0, 9) < 7);
         pick = $urandom_range(0, 99);
         if (pick < 10)
            r.ch = CH_NEWLINE;
         else if (pick < 15)
            r.ch = CH_RETURN;
         if ($urandom_range(0, 3) == 0)
            r.attr = 8'd0;
         if (!r.at_cursor) begin
            pick = $urandom_range(0, 99);
            // most explicit puts land on screen, often on the bottom row
            if (pick >= 12) begin
               r.col = 7'($urandom_range(0, NUM_COLS - 1));
               r.row = (pick < 40) ? 5'(NUM_ROWS - 1) : 5'($urandom_range(0, NUM_ROWS - 1));
            end
         end
      end
      return r;
   endfunction

   function automatic void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
         mismatch_count++;
      end
   endfunction

   // request driver
   always @(posedge clock) begin : driver
      console_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_rsps.push_back(apply_console_request(
               {req_kind, req_ch, req_attr, req_col, req_row, req_at_cursor}));
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
               nxt = pending_reqs.pop_front();
               outstanding++;
               req_valid <= 1'b1;
               req_kind <= nxt.kind;
               req_ch <= nxt.ch;
               req_attr <= nxt.attr;
               req_col <= nxt.col;
               req_row <= nxt.row;
               req_at_cursor <= nxt.at_cursor;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and receiver stall
   always @(posedge clock) begin : monitor
      console_rsp_type got;
      console_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_cursor_col, rsp_cursor_row, rsp_out_of_range, rsp_scrolled,
                   rsp_cell_char, rsp_cell_attr};
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response, expected none, got %p", $time, got);
               mismatch_count++;
            end else begin
               want = expected_rsps.pop_front();
               outstanding--;
               compare_field("cursor_col", 8'(want.cursor_col), 8'(got.cursor_col));
               compare_field("cursor_row", 8'(want.cursor_row), 8'(got.cursor_row));
               compare_field("out_of_range", 8'(want.out_of_range), 8'(got.out_of_range));
               compare_field("scrolled", 8'(want.scrolled), 8'(got.scrolled));
               compare_field("cell_char", want.cell_char, got.cell_char);
               compare_field("cell_attr", want.cell_attr, got.cell_attr);
            end
         end
         if (long_hold_armed && hold_cycles < LONG_HOLD_CYCLES) begin
            hold_cycles++;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("text_console_writer_test NOT OK");
      $finish;
   end

   task automatic push_req(logic [1:0] kind, logic [7:0] ch, logic [7:0] attr,
                           logic [6:0] col, logic [4:0] row, logic at_cursor);
      pending_reqs.push_back('{kind, ch, attr, col, row, at_cursor});
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || outstanding != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_attrs(logic [7:0] dflt, logic [7:0] err);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_DEFAULT_ATTR;
      csr_wdata <= dflt;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_ERROR_ATTR;
      csr_wdata <= err;
      @(posedge clock);
      csr_we <= 1'b0;
      default_attr_cfg = dflt;
      error_attr_cfg = err;
   endtask

   task automatic run_random_phase(int count, int gap, int stall);
      send_gap_pct = gap;
      stall_pct = stall;
      repeat (count) pending_reqs.push_back(random_console_request());
      wait_drained();
   endtask

   initial begin : stimulus
      foreach (screen_model[i]) screen_model[i] = 16'd0;
      cursor_pos = 0;
      default_attr_cfg = DEFAULT_ATTR_RST;
      error_attr_cfg = ERROR_ATTR_RST;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed part, reset attributes
      push_req(KIND_READ, 8'h00, 8'h00, 7'd127, 5'd31, 1'b1);
      push_req(KIND_READ, 8'hff, 8'hff, 7'd127, 5'd31, 1'b0);
      push_req(KIND_READ, 8'h00, 8'h00, 7'd80, 5'd24, 1'b0);
      push_req(KIND_BACKSPACE, 8'h00, 8'h00, 7'd0, 5'd0, 1'b1);
      push_req(KIND_PUT, 8'h41, 8'h00, 7'd0, 5'd0, 1'b1);
      push_req(KIND_PUT, 8'hff, 8'hff, 7'd79, 5'd0, 1'b0);
      // cursor now at column 0 of row 1: backspace reaches back into row 0
      push_req(KIND_BACKSPACE, 8'h00, 8'h00, 7'd0, 5'd0, 1'b1);
      push_req(KIND_PUT, 8'h00, 8'h01, 7'd0, 5'd3, 1'b0);
      push_req(KIND_BACKSPACE, 8'h00, 8'h00, 7'd0, 5'd0, 1'b0);
      push_req(KIND_PUT, 8'h78, 8'h00, 7'd0, 5'd0, 1'b1);
      push_req(KIND_BACKSPACE, 8'h00, 8'h00, 7'd0, 5'd0, 1'b1);
      push_req(KIND_PUT, 8'h79, 8'h00, 7'd0, 5'd0, 1'b1);
      push_req(KIND_BACKSPACE, 8'h00, 8'h00, 7'd0, 5'd0, 1'b1);
      push_req(KIND_PUT, CH_NEWLINE, 8'h00, 7'd0, 5'd0, 1'b1);
      push_req(KIND_PUT, CH_RETURN, 8'h00, 7'd0, 5'd0, 1'b1);
      push_req(KIND_PUT, 8'h42, 8'h07, 7'd80, 5'd5, 1'b0);
      push_req(KIND_PUT, 8'h43, 8'h07, 7'd5, 5'd25, 1'b0);
      push_req(KIND_PUT, 8'h44, 8'h07, 7'd127, 5'd31, 1'b0);
      push_req(KIND_READ, 8'h00, 8'h00, 7'd79, 5'd24, 1'b0);
      push_req(KIND_PUT, 8'h5a, 8'h1e, 7'd79, 5'd24, 1'b0);
      push_req(KIND_PUT, CH_NEWLINE, 8'h00, 7'd3, 5'd24, 1'b0);
      push_req(KIND_PUT, CH_RETURN, 8'h00, 7'd50, 5'd24, 1'b0);
      push_req(KIND_READ, 8'h00, 8'h00, 7'd79, 5'd23, 1'b0);
      push_req(KIND_CLEAR, 8'hff, 8'hff, 7'd127, 5'd31, 1'b1);
      push_req(KIND_READ, 8'h00, 8'h00, 7'd0, 5'd0, 1'b1);
      wait_drained();

      // no idling, opening with a long receiver hold so the block backs up
      write_attrs(8'h00, 8'hff);
      long_hold_armed = 1'b1;
      run_random_phase(PHASE_ITEMS, 0, 0);

      write_attrs(8'hff, 8'h00);
      run_random_phase(PHASE_ITEMS, 46, 0);

      write_attrs(8'($urandom_range(1, 254)), 8'($urandom_range(1, 254)));
      run_random_phase(PHASE_ITEMS, 0, 46);

      write_attrs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      run_random_phase(PHASE_ITEMS, 13, 13);

      // catch stray responses after a full-buffer walk
      repeat (NUM_CELLS + 100) @(posedge clock);
      if (mismatch_count == 0 && expected_rsps.size() == 0)
         $display("text_console_writer_test OK");
      else
         $display("text_console_writer_test NOT OK");
      $finish;
   end

endmodule

// ===== sim.f =====
design/tcw_pkg.sv
design/tcw_decode.sv
design/text_console_writer.sv
bench/text_console_writer_test.sv
